// ----- rtl/kslp_pkg.sv -----
// kslp_pkg: shared types and constants for the key short/long press scanner
// used by every module in rtl/; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kslp_pkg;

    localparam int NUM_KEYS    = 6;
    localparam int KEY_FIELD_W = 6;
    localparam int SCAN_KEYS   = (NUM_KEYS < KEY_FIELD_W) ? NUM_KEYS : KEY_FIELD_W;
    localparam int KEY_IDX_W   = 3;
    localparam int CODE_W      = 4;
    localparam int CNT_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int PHASE_W     = 3;

    localparam logic [CODE_W-1:0] SHORT_BASE = 4'd1;
    localparam logic [CODE_W-1:0] LONG_BASE  = 4'd7;
    localparam logic [CODE_W-1:0] CODE_MAX   = 4'd12;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd3;

    localparam logic [CNT_W-1:0] SETTLE_RST   = 8'd15;
    localparam logic [CNT_W-1:0] DEBOUNCE_RST = 8'd10;
    localparam logic [CNT_W-1:0] SAMPLE_RST   = 8'd10;
    localparam logic [CNT_W-1:0] LONG_RST     = 8'd100;

    localparam logic [PHASE_W-1:0] PH_SETTLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DEBOUNCE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SAMPLE   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HOLD     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RELEASE  = 3'd4;

    typedef struct packed {
        logic [CNT_W-1:0] settle_ticks;
        logic [CNT_W-1:0] debounce_ticks;
        logic [CNT_W-1:0] sample_ticks;
        logic [CNT_W-1:0] long_count;
    } cfg_t;

    typedef struct packed {
        logic              emit;
        logic [CODE_W-1:0] code;
        logic              is_long;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/kslp_cfg.sv -----
// kslp_cfg: configuration register file, plain indexed write port
// depends on kslp_pkg
`timescale 1ns / 1ps
`default_nettype none

module kslp_cfg
    import kslp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CNT_W-1:0]     cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SETTLE:   cfg_next.settle_ticks   = cfg_data;
                REG_DEBOUNCE: cfg_next.debounce_ticks = cfg_data;
                REG_SAMPLE:   cfg_next.sample_ticks   = cfg_data;
                REG_LONG:     cfg_next.long_count     = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ticks   <= SETTLE_RST;
            cfg_reg.debounce_ticks <= DEBOUNCE_RST;
            cfg_reg.sample_ticks   <= SAMPLE_RST;
            cfg_reg.long_count     <= LONG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/kslp_pick.sv -----
// kslp_pick: priority pick of the lowest-numbered pressed key
// depends on kslp_pkg
`timescale 1ns / 1ps
`default_nettype none

module kslp_pick
    import kslp_pkg::*;
(
    input  wire logic [KEY_FIELD_W-1:0] levels,
    output logic                        found,
    output logic [KEY_IDX_W-1:0]        key_idx
);

    always_comb
    begin
        found   = 1'b0;
        key_idx = '0;
        for (int k = SCAN_KEYS - 1; k >= 0; k--)
        begin
            if (!levels[k])
            begin
                found   = 1'b1;
                key_idx = KEY_IDX_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/kslp_core.sv -----
// kslp_core: phase state machine with tick and sample counters
// depends on kslp_pkg and kslp_pick
`timescale 1ns / 1ps
`default_nettype none

module kslp_core
    import kslp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic [KEY_FIELD_W-1:0] levels,
    input  wire cfg_t                   cfg,
    output res_t                        res
);

    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [CNT_W-1:0]     tick_count_reg, tick_count_next;
    logic [CNT_W-1:0]     sample_count_reg, sample_count_next;
    logic [KEY_IDX_W-1:0] chosen_key_reg, chosen_key_next;

    logic                 found;
    logic [KEY_IDX_W-1:0] pick_idx;
    logic                 chosen_down;
    logic [CNT_W-1:0]     sample_inc;
    logic [CNT_W-1:0]     settle_tick;

    kslp_pick u_pick
    (
        .levels  (levels),
        .found   (found),
        .key_idx (pick_idx)
    );

    always_comb
    begin
        chosen_down = 1'b0;
        for (int k = 0; k < KEY_FIELD_W; k++)
        begin
            if (chosen_key_reg == KEY_IDX_W'(k))
            begin
                chosen_down = !levels[k];
            end
        end
    end

    assign sample_inc = (sample_count_reg == CNT_MAX) ? CNT_MAX : sample_count_reg + 1'b1;

    always_comb
    begin
        phase_next        = phase_reg;
        tick_count_next   = tick_count_reg;
        sample_count_next = sample_count_reg;
        chosen_key_next   = chosen_key_reg;
        res.emit          = 1'b0;
        res.code          = '0;
        res.is_long       = 1'b0;
        settle_tick       = tick_count_reg;

        unique case (phase_reg)
            PH_DEBOUNCE:
            begin
                if (tick_count_reg < cfg.debounce_ticks)
                begin
                    tick_count_next = tick_count_reg + 1'b1;
                end
                else
                begin
                    phase_next        = PH_SAMPLE;
                    tick_count_next   = '0;
                    sample_count_next = '0;
                end
            end
            PH_SAMPLE:
            begin
                if (tick_count_reg < cfg.sample_ticks)
                begin
                    tick_count_next = tick_count_reg + 1'b1;
                end
                else if (!chosen_down)
                begin
                    res.emit          = 1'b1;
                    res.code          = CODE_W'(chosen_key_reg) + SHORT_BASE;
                    phase_next        = PH_SETTLE;
                    tick_count_next   = '0;
                    sample_count_next = '0;
                end
                else
                begin
                    tick_count_next   = '0;
                    sample_count_next = sample_inc;
                    if (sample_inc >= cfg.long_count)
                    begin
                        phase_next = PH_HOLD;
                    end
                end
            end
            PH_HOLD:
            begin
                if (!chosen_down)
                begin
                    phase_next      = PH_RELEASE;
                    tick_count_next = '0;
                end
            end
            PH_RELEASE:
            begin
                if (tick_count_reg < cfg.debounce_ticks)
                begin
                    tick_count_next = tick_count_reg + 1'b1;
                end
                else
                begin
                    res.emit          = 1'b1;
                    res.is_long       = 1'b1;
                    res.code          = CODE_W'(chosen_key_reg) + LONG_BASE;
                    phase_next        = PH_SETTLE;
                    tick_count_next   = '0;
                    sample_count_next = '0;
                end
            end
            default:
            begin
                // unused codes restart settling from zero
                if (phase_reg != PH_SETTLE)
                begin
                    settle_tick       = '0;
                    sample_count_next = '0;
                end
                phase_next = PH_SETTLE;
                if (settle_tick < cfg.settle_ticks)
                begin
                    tick_count_next = settle_tick + 1'b1;
                end
                else
                begin
                    tick_count_next = '0;
                    if (found)
                    begin
                        chosen_key_next   = pick_idx;
                        phase_next        = PH_DEBOUNCE;
                        sample_count_next = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SETTLE;
            tick_count_reg   <= '0;
            sample_count_reg <= '0;
            chosen_key_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            tick_count_reg   <= tick_count_next;
            sample_count_reg <= sample_count_next;
            chosen_key_reg   <= chosen_key_next;
        end
    end

    a_hold_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HOLD) |-> !res.emit)
        else $error("code emitted while key held");

    a_emit_to_settle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.emit) |=> (phase_reg == PH_SETTLE && tick_count_reg == '0
            && sample_count_reg == '0))
        else $error("no return to settle after code");

    a_sample_from_debounce: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_DEBOUNCE && phase_next == PH_SAMPLE)
            |=> (sample_count_reg == '0 && tick_count_reg == '0))
        else $error("counters not cleared entering sample");

endmodule

`default_nettype wire

// ----- rtl/key_short_long_press_scanner_unit.sv -----
// key_short_long_press_scanner_unit: top level, tick input stage and code output register
// depends on kslp_pkg, kslp_cfg and kslp_core
//
// one transfer on the key channel is one millisecond tick carrying six
// active-low key levels (bit i is key i+1). the block settles, scans for the
// lowest-numbered pressed key, debounces it and samples it; a release before
// long_count samples gives a short code (1..6), otherwise after release and a
// second debounce a long code (7..12) with long_press set.
// an accepted tick is held in the input stage and processed by the phase
// logic once the output register is free; a resulting code is registered
// and shown on the code channel. one tick per cycle is sustained while the
// code receiver does not stall, limited by the single phase logic pass.
// when the code receiver stalls a waiting code holds, and the input stage
// fills and then raises key_stall until the code is taken. reset clears
// both stages, returns to the settle phase and loads the register defaults
// 15, 10, 10, 100. configuration is written through cfg_wr_en / cfg_index /
// cfg_data, by the user only while no tick is in flight; not enforced.
`timescale 1ns / 1ps
`default_nettype none

module key_short_long_press_scanner_unit
    import kslp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   key_valid,
    output logic                        key_stall,
    input  wire logic [KEY_FIELD_W-1:0] key_levels,
    output logic                        code_valid,
    input  wire logic                   code_stall,
    output logic [CODE_W-1:0]           key_code,
    output logic                        long_press,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CNT_W-1:0]       cfg_data
);

    cfg_t cfg;
    res_t res;

    logic                   s1_valid_reg, s1_valid_next;
    logic [KEY_FIELD_W-1:0] s1_levels_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]      out_code_reg;
    logic                   out_long_reg;

    logic key_xfer;
    logic out_free;
    logic advance;

    kslp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kslp_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .levels (s1_levels_reg),
        .cfg    (cfg),
        .res    (res)
    );

    assign out_free  = !out_valid_reg || !code_stall;
    assign advance   = s1_valid_reg && out_free;
    assign key_stall = s1_valid_reg && !out_free;
    assign key_xfer  = key_valid && !key_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (key_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && res.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!code_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_xfer)
        begin
            s1_levels_reg <= key_levels;
        end
        if (advance && res.emit)
        begin
            out_code_reg <= res.code;
            out_long_reg <= res.is_long;
        end
    end

    assign code_valid = out_valid_reg;
    assign key_code   = out_code_reg;
    assign long_press = out_long_reg;

    a_long_flag: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid |-> (long_press == (key_code >= LONG_BASE)))
        else $error("long flag does not match code");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid |-> (key_code >= SHORT_BASE && key_code <= CODE_MAX))
        else $error("code out of range");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        key_stall |-> (s1_valid_reg && code_valid))
        else $error("stall without a waiting code");

endmodule

`default_nettype wire
